@@ rtl/tsvr_pkg.sv @@
// Shared types, constants and helpers for the tile scanline video renderer.
// No dependencies.
package tsvr_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int LINE_WIDTH = 160;
    localparam int ADDR_W     = $clog2(VRAM_BYTES);
    localparam int WORD_W     = ADDR_W - 1;
    localparam int WORD_DEPTH = VRAM_BYTES / 2;

    localparam logic [8:0] DOTS_SEARCH_END   = 9'd40;
    localparam logic [8:0] DOTS_TRANSFER_END = 9'd200;
    localparam logic [8:0] DOTS_LAST         = 9'd455;
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE         = 8'd153;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_SEARCH   = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    localparam logic [2:0] REG_LAYER_CONTROL = 3'd0;
    localparam logic [2:0] REG_SCROLL_X      = 3'd1;
    localparam logic [2:0] REG_SCROLL_Y      = 3'd2;
    localparam logic [2:0] REG_WINDOW_X      = 3'd3;
    localparam logic [2:0] REG_WINDOW_Y      = 3'd4;
    localparam logic [2:0] REG_BG_PALETTE    = 3'd5;

    typedef struct packed {
        logic        operation;
        logic [12:0] vram_address;
        logic [7:0]  vram_data;
    } in_word_t;

    typedef struct packed {
        logic [1:0] video_mode;
        logic [7:0] line_number;
        logic       pixel_valid;
        logic [7:0] pixel_x;
        logic [1:0] pixel_shade;
        logic [7:0] pixel_gray;
    } out_word_t;

    function automatic logic [7:0] gray_of_shade(input logic [1:0] shade);
        logic [7:0] g;
        case (shade)
            2'd0:    g = 8'hFF;
            2'd1:    g = 8'hCC;
            2'd2:    g = 8'h77;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/tile_scanline_video_renderer.sv @@
// Top level of the tile scanline video renderer: timing, VRAM and pixel pipeline.
// Depends on tsvr_pkg.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one word per item, either a dot
//   tick or a VRAM byte write. out channel (out_valid/out_ready/out_data):
//   exactly one result word per input word, in order, with mode and line after
//   the item and the drawn pixel, if any.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while the block is idle. Unknown indexes ignored.
//   Each accepted word passes the stage 1, stage 2 and output registers.
//   Throughput: one word per cycle unless out_ready stalls. Each tick reads the
//   tile map word in the accept cycle and the 16-bit tile row (both planes) as
//   it enters stage 2, on the second read port of the single 4096 x 16 VRAM.
//   Reset: VRAM is cleared over all WORD_DEPTH (4096) words, one word per cycle;
//   in_ready stays low until it ends. Control registers reset to zero, mode to
//   MODE_SEARCH. Stall: a three-stage pipeline with per-stage enables; input is
//   taken until all stages hold a word and out_ready is low; then in_ready drops.
module tile_scanline_video_renderer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsvr_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tsvr_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    logic [15:0] vram [tsvr_pkg::WORD_DEPTH];

    logic [3:0] layer_control_reg;
    logic [7:0] scroll_x_reg, scroll_y_reg, window_x_reg, window_y_reg, bg_palette_reg;

    logic [8:0] dot_reg, dot_next;
    logic [7:0] line_reg, line_next;
    logic [1:0] mode_reg, mode_next;

    logic [tsvr_pkg::WORD_W:0] clr_reg;
    logic                      clr_done;

    // stage 1: map word read
    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [7:0]  s1_line_reg;
    logic        s1_pix_reg;
    logic [7:0]  s1_x_reg;
    logic [2:0]  s1_fx_reg;
    logic [2:0]  s1_fy_reg;
    logic        s1_hi_reg;
    logic [15:0] s1_map_reg;

    // stage 2: tile row read
    logic        s2_valid_reg;
    logic [1:0]  s2_mode_reg;
    logic [7:0]  s2_line_reg;
    logic        s2_pix_reg;
    logic [7:0]  s2_x_reg;
    logic [2:0]  s2_fx_reg;
    logic [15:0] s2_row_reg;

    logic                out_valid_reg;
    tsvr_pkg::out_word_t out_reg, out_next;

    logic en1, en2, en3, accept;

    logic       is_tick, pix;
    logic [7:0] col;
    logic       in_win;
    logic [8:0] col7;
    logic [7:0] fx, fy;
    logic       map_sel;
    logic [12:0] map_addr;
    logic [7:0] tile_idx;
    logic [11:0] row_addr;
    logic [1:0] color, shade;

    assign en3      = !out_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign clr_done = clr_reg[tsvr_pkg::WORD_W];
    assign in_ready = en1 && clr_done;
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // timing
    always_comb
    begin
        is_tick   = (in_data.operation == tsvr_pkg::OP_TICK);
        dot_next  = dot_reg;
        line_next = line_reg;
        mode_next = mode_reg;
        pix       = 1'b0;
        col       = 8'(dot_reg - tsvr_pkg::DOTS_SEARCH_END);
        if (is_tick)
        begin
            if (line_reg < tsvr_pkg::FIRST_VBLANK_LINE)
            begin
                if (dot_reg < tsvr_pkg::DOTS_SEARCH_END)
                    mode_next = tsvr_pkg::MODE_SEARCH;
                else if (dot_reg < tsvr_pkg::DOTS_TRANSFER_END)
                begin
                    mode_next = tsvr_pkg::MODE_TRANSFER;
                    pix = ({1'b0, col} < 9'(tsvr_pkg::LINE_WIDTH));
                end
                else
                    mode_next = tsvr_pkg::MODE_HBLANK;
            end
            else
                mode_next = tsvr_pkg::MODE_VBLANK;
            if (dot_reg == tsvr_pkg::DOTS_LAST)
            begin
                dot_next  = 9'd0;
                line_next = (line_reg >= tsvr_pkg::LAST_LINE) ? 8'd0 : line_reg + 8'd1;
                mode_next = (line_next >= tsvr_pkg::FIRST_VBLANK_LINE) ?
                            tsvr_pkg::MODE_VBLANK : tsvr_pkg::MODE_SEARCH;
            end
            else
                dot_next = dot_reg + 9'd1;
        end
    end

    // map address
    always_comb
    begin
        col7   = {1'b0, col} + 9'd7;
        in_win = layer_control_reg[0] && (window_y_reg <= line_reg)
                 && (col7 >= {1'b0, window_x_reg});
        if (in_win)
        begin
            fx      = 8'(col7 - {1'b0, window_x_reg});
            fy      = line_reg - window_y_reg;
            map_sel = layer_control_reg[1];
        end
        else
        begin
            fx      = col + scroll_x_reg;
            fy      = line_reg + scroll_y_reg;
            map_sel = layer_control_reg[2];
        end
        map_addr = {2'b11, map_sel, fy[7:3], fx[7:3]};
    end

    // tile row address
    always_comb
    begin
        tile_idx = s1_hi_reg ? s1_map_reg[15:8] : s1_map_reg[7:0];
        row_addr = {!layer_control_reg[3] && !tile_idx[7], tile_idx, s1_fy_reg};
    end

    // shade
    always_comb
    begin
        color = {s2_row_reg[4'd15 - {1'b0, s2_fx_reg}], s2_row_reg[4'd7 - {1'b0, s2_fx_reg}]};
        shade = 2'(bg_palette_reg >> {color, 1'b0});
        out_next             = '0;
        out_next.video_mode  = s2_mode_reg;
        out_next.line_number = s2_line_reg;
        if (s2_pix_reg)
        begin
            out_next.pixel_valid = 1'b1;
            out_next.pixel_x     = s2_x_reg;
            out_next.pixel_shade = shade;
            out_next.pixel_gray  = tsvr_pkg::gray_of_shade(shade);
        end
    end

    // VRAM: clear pass, byte writes, two registered read ports
    always_ff @(posedge clk)
    begin
        if (!clr_done)
            vram[clr_reg[tsvr_pkg::WORD_W-1:0]] <= 16'd0;
        else if (accept && in_data.operation == tsvr_pkg::OP_WRITE)
        begin
            if (in_data.vram_address[0])
                vram[tsvr_pkg::WORD_W'(in_data.vram_address >> 1)][15:8] <= in_data.vram_data;
            else
                vram[tsvr_pkg::WORD_W'(in_data.vram_address >> 1)][7:0] <= in_data.vram_data;
        end
        if (en1)
            s1_map_reg <= vram[tsvr_pkg::WORD_W'(map_addr >> 1)];
        if (en2)
            s2_row_reg <= vram[tsvr_pkg::WORD_W'(row_addr)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg           <= '0;
            layer_control_reg <= '0;
            scroll_x_reg      <= '0;
            scroll_y_reg      <= '0;
            window_x_reg      <= '0;
            window_y_reg      <= '0;
            bg_palette_reg    <= '0;
            dot_reg           <= '0;
            line_reg          <= '0;
            mode_reg          <= tsvr_pkg::MODE_SEARCH;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (!clr_done)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tsvr_pkg::REG_LAYER_CONTROL: layer_control_reg <= cfg_data[3:0];
                    tsvr_pkg::REG_SCROLL_X:      scroll_x_reg      <= cfg_data;
                    tsvr_pkg::REG_SCROLL_Y:      scroll_y_reg      <= cfg_data;
                    tsvr_pkg::REG_WINDOW_X:      window_x_reg      <= cfg_data;
                    tsvr_pkg::REG_WINDOW_Y:      window_y_reg      <= cfg_data;
                    tsvr_pkg::REG_BG_PALETTE:    bg_palette_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                dot_reg  <= dot_next;
                line_reg <= line_next;
                mode_reg <= mode_next;
            end
            if (en1)
                s1_valid_reg <= accept;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mode_reg <= mode_next;
            s1_line_reg <= line_next;
            s1_pix_reg  <= pix;
            s1_x_reg    <= col;
            s1_fx_reg   <= fx[2:0];
            s1_fy_reg   <= fy[2:0];
            s1_hi_reg   <= map_addr[0];
        end
        if (en2)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_line_reg <= s1_line_reg;
            s2_pix_reg  <= s1_pix_reg;
            s2_x_reg    <= s1_x_reg;
            s2_fx_reg   <= s1_fx_reg;
        end
        if (en3)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done |-> !in_ready)
        else $error("input taken during VRAM clear");
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg <= tsvr_pkg::DOTS_LAST)
        else $error("dot counter out of range");
    a_pixel_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pixel_valid |-> out_data.video_mode == tsvr_pkg::MODE_TRANSFER)
        else $error("pixel outside transfer");
    a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pixel_valid |-> out_data.pixel_gray == 8'd0
        && out_data.pixel_x == 8'd0)
        else $error("stale pixel fields");
    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost");

endmodule
